[hw/rtl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants for the Huffman code emitter: command codes,
// the input and result item layouts, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int BYTE_W = 8;

    // Command codes carried in the input item.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_ABSENT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  symbol;
        logic [63:0] code_bits;
        logic [6:0]  code_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;     // write one table entry from the input item
        logic read_en;     // read the table entry named by the input item
        logic align;       // merge the looked-up code behind the pending bits
        logic flush;       // mark the pending bits as one full byte
        logic pop;         // the top byte was taken by the result channel
        logic show_error;  // present the absent-symbol result
    } hce_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic absent;      // looked-up symbol has no code
        logic has_bytes;   // at least one whole byte is in the bit buffer
        logic last_byte;   // the byte on offer is the final whole byte
        logic pending;     // some bits are waiting in the bit buffer
    } hce_status_t;

endpackage

[hw/rtl/hce_datapath.sv]
// ----------------------------------------------------------------------------
// hce_datapath
// Code and length tables, per-symbol valid bits, and the bit buffer that
// packs codes MSB-first into bytes.
// ----------------------------------------------------------------------------
module hce_datapath #(
    parameter int SYMBOL_COUNT = 128,
    parameter int MAX_CODE_LEN = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hce_pkg::in_item_t   s_data,
    input  hce_pkg::hce_ctrl_t  ctrl,
    output hce_pkg::hce_status_t status,
    output hce_pkg::out_item_t  m_data
);
    import hce_pkg::*;

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int AW    = MAX_CODE_LEN + BYTE_W;
    localparam int CNT_W = $clog2(MAX_CODE_LEN + BYTE_W);

    localparam logic [6:0]       MAX_LEN_IN = 7'(MAX_CODE_LEN);
    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_CODE_LEN);
    localparam logic [CNT_W-1:0] CNT_BYTE   = CNT_W'(BYTE_W);

    logic [MAX_CODE_LEN-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;

    logic [MAX_CODE_LEN-1:0] code_rd_reg;
    logic [LEN_W-1:0]        len_rd_reg;
    logic                    hit_reg;

    logic [AW-1:0]    acc_reg;
    logic [CNT_W-1:0] count_reg;

    logic [14:0]             sym_ext;
    logic [IDX_W-1:0]        idx;
    logic                    in_range;
    logic [LEN_W-1:0]        len_sat;
    logic [LEN_W-1:0]        left_shift;
    logic [MAX_CODE_LEN-1:0] code_left;
    logic [AW-1:0]           code_placed;
    logic [CNT_W-1:0]        count_rem;

    assign sym_ext  = {8'b0, s_data.symbol};
    assign idx      = sym_ext[IDX_W-1:0];
    assign in_range = (int'(s_data.symbol) < SYMBOL_COUNT);
    assign len_sat  = (s_data.code_length > MAX_LEN_IN) ? MAX_LEN
                                                        : s_data.code_length[LEN_W-1:0];

    // Table storage: no reset; an entry's data is only used once its valid bit is set.
    always_ff @(posedge aclk) begin
        if (ctrl.load_we && in_range) begin
            code_mem[idx] <= s_data.code_bits[MAX_CODE_LEN-1:0];
            len_mem[idx]  <= len_sat;
        end
        if (ctrl.read_en) begin
            code_rd_reg <= code_mem[idx];
            len_rd_reg  <= len_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctrl.load_we && in_range) begin
                valid_reg[idx] <= 1'b1;
            end
            if (ctrl.read_en) begin
                hit_reg <= in_range && valid_reg[idx];
            end
        end
    end

    // Left-align the code, then place it right behind the pending bits.
    assign left_shift  = MAX_LEN - len_rd_reg;
    assign code_left   = code_rd_reg << left_shift;
    assign code_placed = {code_left, {BYTE_W{1'b0}}} >> count_reg[2:0];
    assign count_rem   = count_reg - CNT_BYTE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            count_reg <= '0;
        end else if (ctrl.align) begin
            acc_reg   <= acc_reg | code_placed;
            count_reg <= count_reg + CNT_W'(len_rd_reg);
        end else if (ctrl.flush) begin
            count_reg <= CNT_BYTE;
        end else if (ctrl.pop) begin
            acc_reg   <= acc_reg << BYTE_W;
            count_reg <= count_rem;
        end
    end

    assign status.absent    = !hit_reg || (len_rd_reg == '0);
    assign status.has_bytes = (count_reg >= CNT_BYTE);
    assign status.last_byte = (count_rem < CNT_BYTE);
    assign status.pending   = (count_reg != '0);

    assign m_data.out_byte = ctrl.show_error ? 8'h00 : acc_reg[AW-1 -: BYTE_W];
    assign m_data.status   = ctrl.show_error ? STATUS_ABSENT : STATUS_OK;
    assign m_data.last     = ctrl.show_error || status.last_byte;

endmodule

[hw/rtl/hce_ctrl.sv]
// ----------------------------------------------------------------------------
// hce_ctrl
// Sequencer for the Huffman code emitter: takes one item at a time and
// steps the datapath through lookup, merge and byte output.
// ----------------------------------------------------------------------------
module hce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           command,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  hce_pkg::hce_status_t status,
    output hce_pkg::hce_ctrl_t   ctrl
);
    import hce_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_ERROR = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (command)
                        CMD_LOAD: begin
                            ctrl.load_we = 1'b1;
                        end
                        CMD_ENCODE: begin
                            ctrl.read_en = 1'b1;
                            state_next   = ST_ALIGN;
                        end
                        CMD_FLUSH: begin
                            if (status.pending) begin
                                ctrl.flush = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ALIGN: begin
                if (status.absent) begin
                    state_next = ST_ERROR;
                end else begin
                    ctrl.align = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = status.has_bytes;
                if (!status.has_bytes) begin
                    state_next = ST_IDLE;
                end else if (m_ready) begin
                    ctrl.pop = 1'b1;
                    if (status.last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERROR: begin
                m_valid         = 1'b1;
                ctrl.show_error = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/huffman_code_emitter.sv]
// ----------------------------------------------------------------------------
// huffman_code_emitter
// Huffman encoder bit packer: a table of codes per symbol and a byte packer
// that sends each code MSB-first as whole bytes.
// ----------------------------------------------------------------------------
// The block works on one item at a time. A load item writes one table entry
// (code value and length, the length saturated to MAX_CODE_LEN; a length of
// zero marks the symbol absent). An encode item is accepted and reads the
// table, then the code is merged behind the pending bits, and then one output
// byte is sent per cycle while m_ready is high; an encode that completes no
// byte still passes through the output state before it is ready again.
// The length of the merged bit string (up to 7 pending bits plus the code)
// sets the number of bytes, and the one-byte result channel limits output to
// one byte per cycle. An encode of a symbol that has no code, or that lies
// outside the table, gives one item with out_byte zero, status one and last
// set, and leaves pending bits alone. A flush item sends the pending bits
// zero-padded as one final byte, held while m_ready is low, only when some
// are pending; otherwise it gives nothing. Every burst of result items ends
// with last set. The code table has no reset; per-symbol valid bits, cleared
// by reset, mark which entries have been loaded, so the block is usable
// right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module huffman_code_emitter #(
    parameter int SYMBOL_COUNT = 128,
    parameter int MAX_CODE_LEN = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hce_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hce_pkg::out_item_t  m_data
);
    import hce_pkg::*;

    hce_ctrl_t   ctrl;
    hce_status_t status;

    // Sequencer: decides which datapath step runs each cycle.
    hce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .command (s_data.command),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Tables and bit buffer; the result item is taken straight from the
    // buffer register, so it stays steady while the channel stalls.
    hce_datapath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
